// ===== src/dsqe_pkg.sv =====
// ----------------------------------------------------------------------------
// dsqe_pkg
// Shared widths, register indexes, state types and helpers of the
// double-sided quad expander.
// ----------------------------------------------------------------------------
package dsqe_pkg;

  localparam int CoordWidth = 24;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 24;
  localparam int UvW        = 17;
  localparam int OffW       = 25;
  localparam int RxW        = 18;
  localparam int SqW        = 2 * CoordWidth;
  localparam int RadW       = 64;
  localparam int RootW      = 32;
  localparam int QuotW      = 18;
  localparam int DivW       = CoordWidth + 25;
  localparam int ProdW      = RxW + 25;
  localparam int SumW       = ((CoordWidth > OffW) ? CoordWidth : OffW) + 2;
  localparam int RootSteps  = RadW / 2;
  localparam int DivSteps   = QuotW;
  localparam int CntW       = 5;
  localparam int QueueDepth = 2;

  localparam logic [UvW-1:0]   OneQ16   = UvW'(65536);
  localparam logic [SqW-1:0]   MinLenSq = SqW'(7);
  localparam logic [RadW-1:0]  WideLim  = RadW'(1) << 47;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENABLE   = 3'd0,
    REG_WIDTH    = 3'd1,
    REG_HEIGHT   = 3'd2,
    REG_U_LEFT   = 3'd3,
    REG_U_RIGHT  = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    FE_IDLE, FE_SQR, FE_CHK, FE_ROOT, FE_DIVI, FE_DIV, FE_MUL, FE_OFF
  } fe_state_e;

  typedef struct packed {
    logic signed [CoordWidth-1:0] ox;
    logic signed [CoordWidth-1:0] oy;
    logic signed [CoordWidth-1:0] oz;
    logic signed [CoordWidth-1:0] nx;
    logic signed [CoordWidth-1:0] ny;
    logic signed [CoordWidth-1:0] nz;
    logic signed [OffW-1:0]       offx;
    logic signed [OffW-1:0]       offy;
    logic signed [OffW-1:0]       offz;
  } job_t;

  typedef struct packed {
    logic [UvW-1:0] u_left;
    logic [UvW-1:0] u_right;
  } uv_cfg_t;

  function automatic logic [CoordWidth-1:0] sat_coord(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'((64'sd1 <<< (CoordWidth - 1)) - 64'sd1);
    lo = -hi - SumW'(1);
    if (v > hi) begin
      sat_coord = hi[CoordWidth-1:0];
    end else if (v < lo) begin
      sat_coord = lo[CoordWidth-1:0];
    end else begin
      sat_coord = v[CoordWidth-1:0];
    end
  endfunction

endpackage

// ===== src/dsqe_front.sv =====
// ----------------------------------------------------------------------------
// dsqe_front
// Accepts quad items, forms the right vector with a shared square-root
// and divider sequence, scales it and hands a job to the vertex queue unless disabled.
// ----------------------------------------------------------------------------
module dsqe_front
  import dsqe_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic signed [CoordWidth-1:0] ox_i,
  input  logic signed [CoordWidth-1:0] oy_i,
  input  logic signed [CoordWidth-1:0] oz_i,
  input  logic signed [CoordWidth-1:0] nx_i,
  input  logic signed [CoordWidth-1:0] ny_i,
  input  logic signed [CoordWidth-1:0] nz_i,
  input  logic                         enable_i,
  input  logic [CfgDataW-1:0]          width_i,
  input  logic [CfgDataW-1:0]          height_i,
  output logic                         job_push_o,
  output job_t                         job_o,
  input  logic                         job_full_i
);
  import dsqe_pkg::*;

  fe_state_e st_q, st_d;

  logic                         hold_vld_q;
  logic signed [CoordWidth-1:0] h_ox_q, h_oy_q, h_oz_q, h_nx_q, h_ny_q, h_nz_q;
  logic                         take;

  job_t                         job_q;
  logic [SqW-1:0]               s_q;
  logic                         wide_q;
  logic [RadW-1:0]              v_q, res_q, bit_q;
  logic [CntW-1:0]              cnt_q;
  logic [RootW-1:0]             div_q;
  logic [RootW-1:0]             rem_x_q, rem_y_q;
  logic [QuotW-1:0]             lo_x_q, lo_y_q, q_x_q, q_y_q;
  logic                         ovf_x_q, ovf_y_q;
  logic signed [RxW-1:0]        rx_q, ry_q;
  logic signed [ProdW-1:0]      px_q, py_q;

  assign full = hold_vld_q;
  assign take = (st_q == FE_IDLE) && hold_vld_q;

  // input holding stage: takes the next item while the core works
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
    end else if (push && !hold_vld_q) begin
      hold_vld_q <= 1'b1;
    end else if (take) begin
      hold_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && !hold_vld_q) begin
      h_ox_q <= ox_i;
      h_oy_q <= oy_i;
      h_oz_q <= oz_i;
      h_nx_q <= nx_i;
      h_ny_q <= ny_i;
      h_nz_q <= nz_i;
    end
  end

  // two square-root steps per cycle
  logic [RadW-1:0] sv [3];
  logic [RadW-1:0] sr [3];
  logic [RadW-1:0] sb [3];
  always_comb begin
    sv[0] = v_q;
    sr[0] = res_q;
    sb[0] = bit_q;
    for (int i = 0; i < 2; i++) begin
      if (sv[i] >= sr[i] + sb[i]) begin
        sv[i+1] = sv[i] - (sr[i] + sb[i]);
        sr[i+1] = (sr[i] >> 1) + sb[i];
      end else begin
        sv[i+1] = sv[i];
        sr[i+1] = sr[i] >> 1;
      end
      sb[i+1] = sb[i] >> 2;
    end
  end

  // two restoring divide steps per cycle for each component
  logic [RootW-1:0]  rxa [3];
  logic [RootW-1:0]  rya [3];
  logic [QuotW-1:0]  lxa [3];
  logic [QuotW-1:0]  lya [3];
  logic [QuotW-1:0]  qxa [3];
  logic [QuotW-1:0]  qya [3];
  logic [RootW:0]    tx, ty;
  always_comb begin
    rxa[0] = rem_x_q;
    rya[0] = rem_y_q;
    lxa[0] = lo_x_q;
    lya[0] = lo_y_q;
    qxa[0] = q_x_q;
    qya[0] = q_y_q;
    tx = '0;
    ty = '0;
    for (int i = 0; i < 2; i++) begin
      tx = {rxa[i], lxa[i][QuotW-1]};
      ty = {rya[i], lya[i][QuotW-1]};
      if (tx >= {1'b0, div_q}) begin
        rxa[i+1] = RootW'(tx - {1'b0, div_q});
        qxa[i+1] = {qxa[i][QuotW-2:0], 1'b1};
      end else begin
        rxa[i+1] = tx[RootW-1:0];
        qxa[i+1] = {qxa[i][QuotW-2:0], 1'b0};
      end
      if (ty >= {1'b0, div_q}) begin
        rya[i+1] = RootW'(ty - {1'b0, div_q});
        qya[i+1] = {qya[i][QuotW-2:0], 1'b1};
      end else begin
        rya[i+1] = ty[RootW-1:0];
        qya[i+1] = {qya[i][QuotW-2:0], 1'b0};
      end
      lxa[i+1] = lxa[i] << 1;
      lya[i+1] = lya[i] << 1;
    end
  end

  // divider setup: dividend is |n| << shift plus half the root
  logic [RootW-1:0]      root;
  logic [CoordWidth-1:0] mag_x, mag_y;
  logic [DivW-1:0]       dvd_x, dvd_y;
  always_comb begin
    root  = (res_q[RootW-1:0] == '0) ? RootW'(1) : res_q[RootW-1:0];
    mag_x = job_q.ny[CoordWidth-1] ? CoordWidth'(-job_q.ny) : CoordWidth'(job_q.ny);
    mag_y = job_q.nx[CoordWidth-1] ? CoordWidth'(-job_q.nx) : CoordWidth'(job_q.nx);
    dvd_x = (DivW'(mag_x) << (wide_q ? 16 : 24)) + DivW'(root >> 1);
    dvd_y = (DivW'(mag_y) << (wide_q ? 16 : 24)) + DivW'(root >> 1);
  end

  // rounding of the scaled offsets
  logic [ProdW-1:0]      pmx, pmy;
  logic [ProdW-1:0]      ofx_m, ofy_m;
  always_comb begin
    pmx    = px_q[ProdW-1] ? ProdW'(-px_q) : ProdW'(px_q);
    pmy    = py_q[ProdW-1] ? ProdW'(-py_q) : ProdW'(py_q);
    ofx_m  = (pmx + ProdW'(65536)) >> 17;
    ofy_m  = (pmy + ProdW'(65536)) >> 17;
  end

  always_comb begin
    st_d       = st_q;
    job_push_o = 1'b0;
    unique case (st_q)
      FE_IDLE: if (take && enable_i) st_d = FE_SQR;
      FE_SQR:  st_d = FE_CHK;
      FE_CHK:  st_d = (s_q < MinLenSq) ? FE_MUL : FE_ROOT;
      FE_ROOT: if (cnt_q == CntW'(RootSteps / 2 - 1)) st_d = FE_DIVI;
      FE_DIVI: st_d = FE_DIV;
      FE_DIV:  if (cnt_q == CntW'(DivSteps / 2 - 1)) st_d = FE_MUL;
      FE_MUL:  st_d = FE_OFF;
      FE_OFF: begin
        if (!job_full_i) begin
          job_push_o = 1'b1;
          st_d       = FE_IDLE;
        end
      end
      default: st_d = FE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= FE_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      FE_IDLE: begin
        job_q.ox <= h_ox_q;
        job_q.oy <= h_oy_q;
        job_q.oz <= h_oz_q;
        job_q.nx <= h_nx_q;
        job_q.ny <= h_ny_q;
        job_q.nz <= h_nz_q;
      end
      FE_SQR: begin
        s_q <= SqW'(job_q.nx * job_q.nx) + SqW'(job_q.ny * job_q.ny);
      end
      FE_CHK: begin
        rx_q   <= RxW'(OneQ16);
        ry_q   <= '0;
        wide_q <= RadW'(s_q) > WideLim;
        v_q    <= (RadW'(s_q) > WideLim) ? RadW'(s_q) : (RadW'(s_q) << 16);
        res_q  <= '0;
        bit_q  <= RadW'(1) << (RadW - 2);
        cnt_q  <= '0;
      end
      FE_ROOT: begin
        v_q   <= sv[2];
        res_q <= sr[2];
        bit_q <= sb[2];
        cnt_q <= cnt_q + CntW'(1);
      end
      FE_DIVI: begin
        div_q   <= root;
        ovf_x_q <= (dvd_x >> QuotW) >= DivW'(root);
        ovf_y_q <= (dvd_y >> QuotW) >= DivW'(root);
        rem_x_q <= RootW'(dvd_x >> QuotW);
        rem_y_q <= RootW'(dvd_y >> QuotW);
        lo_x_q  <= dvd_x[QuotW-1:0];
        lo_y_q  <= dvd_y[QuotW-1:0];
        q_x_q   <= '0;
        q_y_q   <= '0;
        cnt_q   <= '0;
      end
      FE_DIV: begin
        rem_x_q <= rxa[2];
        rem_y_q <= rya[2];
        lo_x_q  <= lxa[2];
        lo_y_q  <= lya[2];
        q_x_q   <= qxa[2];
        q_y_q   <= qya[2];
        cnt_q   <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(DivSteps / 2 - 1)) begin
          // right = (-ny, nx) / length
          rx_q <= (job_q.ny > 0) ? -RxW'(qxa[2] > QuotW'(OneQ16) || ovf_x_q ?
                  QuotW'(OneQ16) : qxa[2]) : RxW'(qxa[2] > QuotW'(OneQ16) || ovf_x_q ?
                  QuotW'(OneQ16) : qxa[2]);
          ry_q <= (job_q.nx < 0) ? -RxW'(qya[2] > QuotW'(OneQ16) || ovf_y_q ?
                  QuotW'(OneQ16) : qya[2]) : RxW'(qya[2] > QuotW'(OneQ16) || ovf_y_q ?
                  QuotW'(OneQ16) : qya[2]);
        end
      end
      FE_MUL: begin
        px_q <= ProdW'(rx_q * $signed({1'b0, width_i}));
        py_q <= ProdW'(ry_q * $signed({1'b0, width_i}));
      end
      FE_OFF: begin
        job_q.offx <= px_q[ProdW-1] ? -OffW'(ofx_m) : OffW'(ofx_m);
        job_q.offy <= py_q[ProdW-1] ? -OffW'(ofy_m) : OffW'(ofy_m);
        job_q.offz <= OffW'((OffW'(height_i) + OffW'(1)) >> 1);
      end
      default: ;
    endcase
  end

  // offsets are formed combinationally from the products registered in FE_MUL
  assign job_o = '{ox: job_q.ox, oy: job_q.oy, oz: job_q.oz, nx: job_q.nx,
                   ny: job_q.ny, nz: job_q.nz,
                   offx: px_q[ProdW-1] ? -OffW'(ofx_m) : OffW'(ofx_m),
                   offy: py_q[ProdW-1] ? -OffW'(ofy_m) : OffW'(ofy_m),
                   offz: OffW'((OffW'(height_i) + OffW'(1)) >> 1)};

  take_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> st_q == FE_IDLE)
    else $error("item taken while core busy");
  push_after_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push_o |=> st_q == FE_IDLE)
    else $error("core not idle after job push");
  root_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == FE_DIV |-> bit_q == '0)
    else $error("divide started before square root finished");

endmodule

// ===== src/dsqe_queue.sv =====
// ----------------------------------------------------------------------------
// dsqe_queue
// Short job queue between the front and the vertex generator.
// ----------------------------------------------------------------------------
module dsqe_queue
  import dsqe_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dsqe_pkg::job_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output dsqe_pkg::job_t rdata_o,
  output logic           empty_o
);
  import dsqe_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  job_t             mem_q [QueueDepth];
  logic [PtrW-1:0]  wp_q, rp_q;
  logic [PtrW:0]    cnt_q;

  assign full_o  = cnt_q == (PtrW+1)'(QueueDepth);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + PtrW'(1);
      if (pop_i)  rp_q <= rp_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end

  no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("job queue overflow");
  no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("job queue underflow");
  count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(QueueDepth))
    else $error("job queue count out of range");

endmodule

// ===== src/dsqe_back.sv =====
// ----------------------------------------------------------------------------
// dsqe_back
// Walks the eight vertices of each queued job, one per cycle while the
// receiver pops, into an output register.
// ----------------------------------------------------------------------------
module dsqe_back
  import dsqe_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dsqe_pkg::job_t               job_i,
  input  logic                         job_empty_i,
  output logic                         job_pop_o,
  input  dsqe_pkg::uv_cfg_t            uv_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [CoordWidth-1:0]        vx_o,
  output logic [CoordWidth-1:0]        vy_o,
  output logic [CoordWidth-1:0]        vz_o,
  output logic [UvW-1:0]               u_o,
  output logic [UvW-1:0]               v_o,
  output logic                         back_o,
  output logic [1:0]                   corner_o,
  output logic                         last_o
);
  import dsqe_pkg::*;

  logic                   vld_q;
  logic [2:0]             k_q;
  logic                   adv;
  logic                   bk;
  logic [1:0]             c;
  logic                   sxneg, syneg;
  logic signed [SumW-1:0] sx, sy, sz;

  assign adv       = !job_empty_i && (!vld_q || pop);
  assign job_pop_o = adv && (k_q == 3'd7);
  assign empty     = !vld_q;

  always_comb begin
    bk    = k_q[2];
    c     = bk ? ~k_q[1:0] : k_q[1:0];
    sxneg = (c == 2'd0) || (c == 2'd3);
    syneg = !c[1];
    sx = SumW'(job_i.ox) + SumW'(job_i.nx) + (sxneg ? -SumW'(job_i.offx) : SumW'(job_i.offx));
    sy = SumW'(job_i.oy) + SumW'(job_i.ny) + (sxneg ? -SumW'(job_i.offy) : SumW'(job_i.offy));
    sz = SumW'(job_i.oz) + SumW'(job_i.nz) + (syneg ? -SumW'(job_i.offz) : SumW'(job_i.offz));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      k_q   <= '0;
    end else begin
      if (adv) begin
        vld_q <= 1'b1;
        k_q   <= k_q + 3'd1;
      end else if (pop) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vx_o     <= sat_coord(sx);
      vy_o     <= sat_coord(sy);
      vz_o     <= sat_coord(sz);
      // front face mirrors U
      u_o      <= (bk ^ sxneg) ? uv_i.u_right : uv_i.u_left;
      v_o      <= syneg ? OneQ16 : '0;
      back_o   <= bk;
      corner_o <= c;
      last_o   <= k_q == 3'd7;
    end
  end

  last_is_back_bl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && last_o |-> back_o && corner_o == 2'd0)
    else $error("last vertex is not the back bottom-left corner");
  pop_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |-> k_q == 3'd7 && !job_empty_i)
    else $error("job dropped before all vertices sent");
  run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && pop && !last_o |=> vld_q)
    else $error("gap inside a vertex run");

endmodule

// ===== src/double_sided_quad_expander_top.sv =====
// ----------------------------------------------------------------------------
// double_sided_quad_expander_top
// Expands a quad center and normal into eight vertices of a two-sided quad.
// ----------------------------------------------------------------------------
// Each accepted item yields eight vertices, one per cycle while the receiver pops, on the
// output register (front corners 0..3, then back corners 3..0, last set on the eighth);
// with enable low an item is taken and yields nothing. The front computes the
// right vector with a square-root unit and a divider that share one sequencer
// (2 steps per cycle). For a normal with horizontal length above 0.01 it runs the
// root, then divider setup and the divide, then scaling and the hand-off; otherwise
// it skips root and divide, and the eight vertices per item on the back side
// set the rate. A two-entry job queue and an input holding register let the
// front start the next item while earlier vertices are still being
// transferred. Configuration writes are always ready; write them only while
// no item is in flight.
module double_sided_quad_expander_top
  import dsqe_pkg::*;
(
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [dsqe_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [dsqe_pkg::CfgDataW-1:0]         cfg_data_i,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [dsqe_pkg::CoordWidth-1:0] origin_x_i,
  input  logic signed [dsqe_pkg::CoordWidth-1:0] origin_y_i,
  input  logic signed [dsqe_pkg::CoordWidth-1:0] origin_z_i,
  input  logic signed [dsqe_pkg::CoordWidth-1:0] normal_x_i,
  input  logic signed [dsqe_pkg::CoordWidth-1:0] normal_y_i,
  input  logic signed [dsqe_pkg::CoordWidth-1:0] normal_z_i,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [dsqe_pkg::CoordWidth-1:0] vertex_x_o,
  output logic signed [dsqe_pkg::CoordWidth-1:0] vertex_y_o,
  output logic signed [dsqe_pkg::CoordWidth-1:0] vertex_z_o,
  output logic [dsqe_pkg::UvW-1:0]              tex_u_o,
  output logic [dsqe_pkg::UvW-1:0]              tex_v_o,
  output logic                                  back_face_o,
  output logic [1:0]                            corner_o,
  output logic                                  last_o
);
  import dsqe_pkg::*;

  logic                enable_q;
  logic [CfgDataW-1:0] width_q, height_q;
  uv_cfg_t             uv_q;

  job_t job_w, job_r;
  logic job_push, job_pop, job_full, job_empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      width_q    <= '0;
      height_q   <= '0;
      uv_q       <= '{u_left: '0, u_right: OneQ16};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ENABLE:  enable_q       <= cfg_data_i[0];
        REG_WIDTH:   width_q        <= cfg_data_i;
        REG_HEIGHT:  height_q       <= cfg_data_i;
        REG_U_LEFT:  uv_q.u_left    <= cfg_data_i[UvW-1:0];
        REG_U_RIGHT: uv_q.u_right   <= cfg_data_i[UvW-1:0];
        default: ;
      endcase
    end
  end

  dsqe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .ox_i       (origin_x_i),
    .oy_i       (origin_y_i),
    .oz_i       (origin_z_i),
    .nx_i       (normal_x_i),
    .ny_i       (normal_y_i),
    .nz_i       (normal_z_i),
    .enable_i   (enable_q),
    .width_i    (width_q),
    .height_i   (height_q),
    .job_push_o (job_push),
    .job_o      (job_w),
    .job_full_i (job_full)
  );

  dsqe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_w),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .rdata_o (job_r),
    .empty_o (job_empty)
  );

  dsqe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_r),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .uv_i        (uv_q),
    .empty       (empty),
    .pop         (pop),
    .vx_o        (vertex_x_o),
    .vy_o        (vertex_y_o),
    .vz_o        (vertex_z_o),
    .u_o         (tex_u_o),
    .v_o         (tex_v_o),
    .back_o      (back_face_o),
    .corner_o    (corner_o),
    .last_o      (last_o)
  );

endmodule

// ===== bench/double_sided_quad_expander_top_tb.sv =====
// ----------------------------------------------------------------------------
// double_sided_quad_expander_top_tb
// Self-checking bench: drives quad centers and normals through the push/full
// side, predicts the eight vertices of each quad and checks every pop transfer
// field by field. Register settings change between phases while idle.
// ----------------------------------------------------------------------------
module double_sided_quad_expander_top_tb;
  import dsqe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = CoordWidth;
  localparam int WatchLimit = 20000;
  localparam int LongStall = 400;

  typedef struct {
    logic signed [CW-1:0] ox, oy, oz, nx, ny, nz;
  } quad_t;

  typedef struct {
    logic [CW-1:0]  x, y, z;
    logic [UvW-1:0] u, v;
    logic           back;
    logic [1:0]     corner;
    logic           last;
  } vertex_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic push_q, full_s, empty_s, pop_q;
  logic signed [CW-1:0] ox_q, oy_q, oz_q, nx_q, ny_q, nz_q;
  logic signed [CW-1:0] vx_s, vy_s, vz_s;
  logic [UvW-1:0] u_s, v_s;
  logic back_s, last_s;
  logic [1:0] corner_s;

  // shadow registers
  logic           sh_enable;
  logic [23:0]    sh_width, sh_height;
  logic [UvW-1:0] sh_u_left, sh_u_right;

  quad_t   pending_quads[$];
  vertex_t expected_vertices[$];
  int      error_count = 0;
  int      idle_cycles = 0;
  int      hold_off = 0;
  int      long_stall = 0;
  bit      stall_start = 0;
  bit      drain_mode = 0;
  int      push_gap = 0;

  double_sided_quad_expander_top u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .push(push_q), .full(full_s),
    .origin_x_i(ox_q), .origin_y_i(oy_q), .origin_z_i(oz_q),
    .normal_x_i(nx_q), .normal_y_i(ny_q), .normal_z_i(nz_q),
    .empty(empty_s), .pop(pop_q),
    .vertex_x_o(vx_s), .vertex_y_o(vy_s), .vertex_z_o(vz_s),
    .tex_u_o(u_s), .tex_v_o(v_s), .back_face_o(back_s),
    .corner_o(corner_s), .last_o(last_s)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned a);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > a) b >>= 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint round_div(input longint num, input longint unsigned den);
    longint unsigned mag, q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [CW-1:0] clamp_coord(input longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CW-1:0];
  endfunction

  task automatic expand_quad(input quad_t q);
    longint ox, oy, oz, nx, ny, nz, rx, ry, offx, offy, offz, sx, sy;
    longint unsigned s, l;
    int c;
    bit bk;
    vertex_t vt;
    if (!sh_enable) return;
    ox = q.ox; oy = q.oy; oz = q.oz; nx = q.nx; ny = q.ny; nz = q.nz;
    s = nx * nx + ny * ny;
    if (s * 10000 > 65536) begin
      l = int_sqrt(s << 16);
      if (l == 0) l = 1;
      rx = round_div(-ny * (longint'(1) << 24), l);
      ry = round_div(nx * (longint'(1) << 24), l);
      if (rx > 65536) rx = 65536;
      if (rx < -65536) rx = -65536;
      if (ry > 65536) ry = 65536;
      if (ry < -65536) ry = -65536;
    end else begin
      rx = 65536;
      ry = 0;
    end
    offx = round_div(rx * longint'(sh_width), 64'd1 << 17);
    offy = round_div(ry * longint'(sh_width), 64'd1 << 17);
    offz = (longint'(sh_height) + 1) >>> 1;
    for (int k = 0; k < 8; k++) begin
      bk = k >= 4;
      c = bk ? 7 - k : k;
      sx = (c == 0 || c == 3) ? -1 : 1;
      sy = (c < 2) ? -1 : 1;
      vt.x = clamp_coord(ox + sx * offx + nx);
      vt.y = clamp_coord(oy + sx * offy + ny);
      vt.z = clamp_coord(oz + sy * offz + nz);
      if (bk) vt.u = sx < 0 ? sh_u_left : sh_u_right;
      else    vt.u = sx < 0 ? sh_u_right : sh_u_left;
      vt.v = sy < 0 ? OneQ16 : '0;
      vt.back = bk;
      vt.corner = c[1:0];
      vt.last = (k == 7);
      expected_vertices.push_back(vt);
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    $display("MISMATCH %s: got %0h want %0h", what, got, want);
  endtask

  function automatic int rand_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // driver: predictions are made on the transfer, so config is current
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      push_q <= 0;
      push_gap <= 0;
      {ox_q, oy_q, oz_q, nx_q, ny_q, nz_q} <= '0;
    end else begin
      if (push_q && !full_s) expand_quad(pending_quads.pop_front());
      if (push_q && full_s) begin
        // hold the offered item
      end else if (push_gap > 0) begin
        push_gap <= push_gap - 1;
        push_q <= 0;
      end else if (pending_quads.size() > 0) begin
        push_q <= 1;
        ox_q <= pending_quads[0].ox; oy_q <= pending_quads[0].oy;
        oz_q <= pending_quads[0].oz; nx_q <= pending_quads[0].nx;
        ny_q <= pending_quads[0].ny; nz_q <= pending_quads[0].nz;
        push_gap <= rand_gap();
      end else begin
        push_q <= 0;
      end
    end
  end

  // long receiver stall, counted on its own
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      long_stall <= 0;
    end else if (stall_start) begin
      long_stall <= LongStall;
    end else if (long_stall > 0) begin
      long_stall <= long_stall - 1;
    end
  end

  // monitor and receiver
  always @(posedge clk or negedge rst_n) begin
    vertex_t w;
    if (!rst_n) begin
      pop_q <= 0;
    end else begin
      if (pop_q && !empty_s) begin
        if (expected_vertices.size() == 0) begin
          report_mismatch("unexpected vertex", vx_s, 0);
        end else begin
          w = expected_vertices.pop_front();
          if (vx_s !== w.x) report_mismatch("vertex_x", vx_s, w.x);
          if (vy_s !== w.y) report_mismatch("vertex_y", vy_s, w.y);
          if (vz_s !== w.z) report_mismatch("vertex_z", vz_s, w.z);
          if (u_s !== w.u) report_mismatch("tex_u", u_s, w.u);
          if (v_s !== w.v) report_mismatch("tex_v", v_s, w.v);
          if (back_s !== w.back) report_mismatch("back_face", back_s, w.back);
          if (corner_s !== w.corner) report_mismatch("corner", corner_s, w.corner);
          if (last_s !== w.last) report_mismatch("last", last_s, w.last);
        end
      end
      if (stall_start || long_stall > 0) begin
        pop_q <= 0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        pop_q <= 0;
      end else if (drain_mode) begin
        pop_q <= 1;
      end else begin
        pop_q <= ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 30) == 0) hold_off <= rand_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((push_q && !full_s) || (pop_q && !empty_s) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      REG_ENABLE:  sh_enable = val[0];
      REG_WIDTH:   sh_width = val;
      REG_HEIGHT:  sh_height = val;
      REG_U_LEFT:  sh_u_left = val[UvW-1:0];
      REG_U_RIGHT: sh_u_right = val[UvW-1:0];
      default: ;
    endcase
    // let valid drop before the next write
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (pending_quads.size() > 0 || push_q || expected_vertices.size() > 0)
      @(posedge clk);
    // the front may still be busy on an item that yields nothing
    repeat (60) @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(CW-1){1'b1}}};
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return CW'($urandom_range(0, 6)) - CW'(3);
      3: return $signed(CW'($urandom_range(0, 4000))) - $signed(CW'(2000));
      default: return CW'($urandom());
    endcase
  endfunction

  task automatic add_quad(input logic signed [CW-1:0] ox, oy, oz, nx, ny, nz);
    quad_t q;
    q.ox = ox; q.oy = oy; q.oz = oz; q.nx = nx; q.ny = ny; q.nz = nz;
    pending_quads.push_back(q);
  endtask

  task automatic add_random(input int n);
    repeat (n) add_quad(rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord());
  endtask

  localparam logic signed [CW-1:0] MaxC = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MinC = {1'b1, {(CW-1){1'b0}}};

  initial begin
    rst_n = 0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    sh_enable = 0; sh_width = 0; sh_height = 0;
    sh_u_left = 0; sh_u_right = OneQ16;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // disabled at reset: items are taken, nothing comes out
    add_quad(1, 2, 3, 256, 0, 0);
    add_quad(MaxC, MinC, 0, -300, 500, 7);
    wait_idle();

    write_reg(REG_ENABLE, 1);
    write_reg(REG_WIDTH, 24'd512);
    write_reg(REG_HEIGHT, 24'd257);
    // degenerate normals, at and around the 0.01 threshold, and unit normals
    add_quad(0, 0, 0, 0, 0, 0);
    add_quad(100, -100, 50, 2, 1, 0);
    add_quad(100, -100, 50, 3, 0, 0);
    add_quad(0, 0, 0, 2, 2, -1);
    add_quad(0, 0, 0, 256, 0, 0);
    add_quad(0, 0, 0, 0, -256, 0);
    add_quad(0, 0, 0, 181, 181, 10);
    // saturation at both ends
    add_quad(MaxC, MaxC, MaxC, MaxC, MaxC, MaxC);
    add_quad(MinC, MinC, MinC, MinC, MinC, MinC);
    add_quad(MaxC, MinC, MaxC, MinC, MaxC, 0);
    wait_idle();

    // extremes of width, height and U, reversed and out of range U
    write_reg(REG_WIDTH, 24'hFFFFFF);
    write_reg(REG_HEIGHT, 24'hFFFFFF);
    write_reg(REG_U_LEFT, 24'h1FFFF);
    write_reg(REG_U_RIGHT, 24'd0);
    add_quad(0, 0, 0, 1000, -777, 3);
    add_quad(-5000, 5000, 0, -1, 300, 0);
    add_quad(0, 0, 0, 0, 0, 0);
    add_random(30);
    wait_idle();

    write_reg(REG_WIDTH, 24'd0);
    write_reg(REG_HEIGHT, 24'd0);
    write_reg(REG_U_LEFT, 24'd16384);
    write_reg(REG_U_RIGHT, 24'd49152);
    add_random(30);
    wait_idle();

    // long receiver stall while the sender keeps offering
    write_reg(REG_WIDTH, CfgDataW'($urandom()));
    write_reg(REG_HEIGHT, CfgDataW'($urandom()));
    stall_start <= 1;
    @(posedge clk);
    stall_start <= 0;
    add_random(60);
    wait_idle();

    write_reg(REG_ENABLE, 0);
    add_random(10);
    wait_idle();

    write_reg(REG_ENABLE, 1);
    write_reg(REG_U_LEFT, CfgDataW'($urandom_range(0, 65536)));
    write_reg(REG_U_RIGHT, CfgDataW'($urandom_range(0, 65536)));
    add_random(60);
    wait_idle();

    drain_mode = 1;
    repeat (100) @(posedge clk);
    if (error_count == 0 && expected_vertices.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/dsqe_pkg.sv
src/dsqe_front.sv
src/dsqe_queue.sv
src/dsqe_back.sv
src/double_sided_quad_expander_top.sv
bench/double_sided_quad_expander_top_tb.sv
